// ===== rtl/core/mpwl_pkg.sv =====
// shared types and constants for the pixel window/level block
// used by mpwl_csr and medical_pixel_window_level_top; no dependencies
`default_nettype none

package mpwl_pkg;

   // fixed-point fraction bits of slope, intercept, gain and offset
   localparam int FRAC_BITS_DEFAULT = 16;

   // configuration port geometry
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RESCALE_SLOPE     = 4'd0,
      REG_RESCALE_INTERCEPT = 4'd1,
      REG_WINDOW_GAIN       = 4'd2,
      REG_WINDOW_OFFSET     = 4'd3,
      REG_LITTLE_ENDIAN     = 4'd4,
      REG_SIGNED_PIXELS     = 4'd5,
      REG_VALID_BITS        = 4'd6,
      REG_INVERT_OUTPUT     = 4'd7
   } reg_index_type;

   // reset values
   localparam logic [31:0] RESCALE_SLOPE_RST     = 32'd3932;
   localparam logic [31:0] RESCALE_INTERCEPT_RST = 32'd0;
   localparam logic [31:0] WINDOW_GAIN_RST       = 32'd256;
   localparam logic [23:0] WINDOW_OFFSET_RST     = 24'd8388608;
   localparam logic [4:0]  VALID_BITS_RST        = 5'd16;

   // sample limits
   localparam logic [15:0] GRAY_POS_MAX  = 16'h7fff;  // 32767
   localparam logic [15:0] GRAY_NEG_MOST = 16'h8000;  // -32768
   localparam logic [16:0] GRAY_NEG_MIN  = 17'h18001; // -32767
   localparam logic [4:0]  NARROW_BITS   = 5'd8;
   localparam logic [7:0]  GRAY_WHITE    = 8'hff;

   // configuration register set
   typedef struct packed {
      logic signed [31:0] rescale_slope;
      logic signed [31:0] rescale_intercept;
      logic [31:0]        window_gain;
      logic [23:0]        window_offset;
      logic               little_endian;
      logic               signed_pixels;
      logic [4:0]         valid_bits;
      logic               invert_output;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/mpwl_csr.sv =====
// configuration registers of the pixel window/level block
// depends on mpwl_pkg
`default_nettype none

module mpwl_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [mpwl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [mpwl_pkg::CSR_DATA_W-1:0]    csr_data,
   output mpwl_pkg::cfg_type                  cfg
);
   import mpwl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_RESCALE_SLOPE:     cfg_in.rescale_slope     = csr_data;
            REG_RESCALE_INTERCEPT: cfg_in.rescale_intercept = csr_data;
            REG_WINDOW_GAIN:       cfg_in.window_gain       = csr_data;
            REG_WINDOW_OFFSET:     cfg_in.window_offset     = csr_data[23:0];
            REG_LITTLE_ENDIAN:     cfg_in.little_endian     = csr_data[0];
            REG_SIGNED_PIXELS:     cfg_in.signed_pixels     = csr_data[0];
            REG_VALID_BITS:        cfg_in.valid_bits        = csr_data[4:0];
            REG_INVERT_OUTPUT:     cfg_in.invert_output     = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rescale_slope     <= RESCALE_SLOPE_RST;
         cfg_ff.rescale_intercept <= RESCALE_INTERCEPT_RST;
         cfg_ff.window_gain       <= WINDOW_GAIN_RST;
         cfg_ff.window_offset     <= WINDOW_OFFSET_RST;
         cfg_ff.little_endian     <= 1'b1;
         cfg_ff.signed_pixels     <= 1'b0;
         cfg_ff.valid_bits        <= VALID_BITS_RST;
         cfg_ff.invert_output     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/medical_pixel_window_level_top.sv =====
// Pixel window/level: maps two-byte grayscale samples to 8-bit display values.
//
// Channels: req_ takes one request per sample, req_tdata = {second_byte, first_byte}.
// rsp_ returns one display_gray per request, in order, in rsp_tdata[7:0].
// csr_ writes one configuration register per handshake; csr_ready is always high.
// Registers must be changed only while no request is in flight; the block does not enforce it.
// Throughput: one request per clock while rsp_tready allows, set by the six-stage pipeline
// (assemble, slope multiply, intercept add, truncate/saturate, gain multiply,
// window/clamp) with two 32-bit-class multipliers each in a stage of its own.
// Stalls: every stage holds its item while the next is full and not moving;
// bubbles close up, so requests keep being taken while a result waits on
// rsp_tready until all six stages hold an item.
// Reset: synchronous, empties the pipeline and loads the register defaults
// (slope 3932, intercept 0, gain 256, offset 128.0, little endian, unsigned,
// 16 valid bits, no inversion).
// Depends on mpwl_pkg and mpwl_csr.
`default_nettype none

module medical_pixel_window_level_top #(
   parameter int FRAC_BITS = mpwl_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   // request: [7:0] first_byte, [15:8] second_byte
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [15:0]                       req_tdata,
   // response: [7:0] display_gray
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [7:0]                        rsp_tdata,
   // configuration write
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [mpwl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [mpwl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mpwl_pkg::*;

   localparam int STAGES = 6;

   cfg_type cfg;

   mpwl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // stage handshake: a stage loads when it is empty or its item moves on
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   stage_ready;

   always_comb begin
      stage_ready[STAGES] = rsp_tready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      for (int i = 0; i < STAGES; i++) begin
         if (stage_ready[i]) begin
            valid_in[i] = (i == 0) ? req_tvalid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[0];

   // narrow passthrough byte, carried alongside the wide path
   logic [7:0] pass_ff [STAGES-1];
   logic [7:0] pass_in;
   logic       narrow_ff [STAGES-1];
   logic       narrow_in;

   // stage 1: assemble the 16-bit sample and clamp little-endian values
   logic [7:0]         first_byte;
   logic [7:0]         second_byte;
   logic [15:0]        sample;
   logic signed [16:0] gray_in;
   logic signed [16:0] gray_ff;

   assign first_byte  = req_tdata[7:0];
   assign second_byte = req_tdata[15:8];

   always_comb begin
      sample    = cfg.little_endian ? {second_byte, first_byte} : {first_byte, second_byte};
      narrow_in = (cfg.valid_bits <= NARROW_BITS);
      pass_in   = cfg.little_endian ? first_byte : second_byte;
      if (cfg.signed_pixels) begin
         gray_in = {sample[15], sample};
         if (cfg.little_endian && (sample == GRAY_NEG_MOST)) begin
            gray_in = GRAY_NEG_MIN;
         end
      end else begin
         gray_in = {1'b0, sample};
         if (cfg.little_endian && (sample > GRAY_POS_MAX)) begin
            gray_in = {1'b0, GRAY_POS_MAX};
         end
      end
   end

   // stage 2: multiply by the rescale slope
   logic signed [48:0] slope_prod_in;
   logic signed [48:0] slope_prod_ff;

   assign slope_prod_in = 49'(gray_ff) * 49'(cfg.rescale_slope);

   // stage 3: add the rescale intercept
   logic signed [49:0] rescale_sum_in;
   logic signed [49:0] rescale_sum_ff;

   assign rescale_sum_in = {slope_prod_ff[48], slope_prod_ff}
                         + {{18{cfg.rescale_intercept[31]}}, cfg.rescale_intercept};

   // stage 4: truncate toward zero, saturate magnitude to 32 bits
   logic [49:0] sum_abs;
   logic [49:0] sum_shift;
   logic [31:0] rescale_mag_in;
   logic [31:0] rescale_mag_ff;
   logic        rescale_neg_in;
   logic        rescale_neg_ff [2];

   always_comb begin
      sum_abs        = rescale_sum_ff[49] ? (~rescale_sum_ff + 50'd1) : rescale_sum_ff;
      sum_shift      = sum_abs >> FRAC_BITS;
      rescale_mag_in = (|sum_shift[49:32]) ? '1 : sum_shift[31:0];
      rescale_neg_in = rescale_sum_ff[49] && (sum_shift != '0);
   end

   // stage 5: multiply magnitude by the window gain
   logic [63:0] gain_prod_in;
   logic [63:0] gain_prod_ff;

   assign gain_prod_in = {32'd0, rescale_mag_ff} * {32'd0, cfg.window_gain};

   // stage 6: add or subtract the offset, clamp to 0..255 or take the narrow byte, optional invert
   logic [64:0] win_sum;
   logic [64:0] win_sum_shift;
   logic [23:0] win_diff;
   logic [23:0] win_diff_shift;
   logic [7:0]  gray_sel;
   logic [7:0]  display_in;
   logic [7:0]  display_ff;

   always_comb begin
      win_sum        = {1'b0, gain_prod_ff} + {41'd0, cfg.window_offset};
      win_sum_shift  = win_sum >> FRAC_BITS;
      win_diff       = cfg.window_offset - gain_prod_ff[23:0];
      win_diff_shift = win_diff >> FRAC_BITS;
      if (rescale_neg_ff[1]) begin
         if (gain_prod_ff >= {40'd0, cfg.window_offset}) begin
            gray_sel = 8'd0;
         end else if (win_diff_shift > 24'd255) begin
            gray_sel = GRAY_WHITE;
         end else begin
            gray_sel = win_diff_shift[7:0];
         end
      end else if (win_sum_shift > 65'd255) begin
         gray_sel = GRAY_WHITE;
      end else begin
         gray_sel = win_sum_shift[7:0];
      end
      if (narrow_ff[STAGES-2]) begin
         gray_sel = pass_ff[STAGES-2];
      end
      display_in = cfg.invert_output ? (GRAY_WHITE - gray_sel) : gray_sel;
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         gray_ff      <= gray_in;
         pass_ff[0]   <= pass_in;
         narrow_ff[0] <= narrow_in;
      end
      if (stage_ready[1]) begin
         slope_prod_ff <= slope_prod_in;
         pass_ff[1]    <= pass_ff[0];
         narrow_ff[1]  <= narrow_ff[0];
      end
      if (stage_ready[2]) begin
         rescale_sum_ff <= rescale_sum_in;
         pass_ff[2]     <= pass_ff[1];
         narrow_ff[2]   <= narrow_ff[1];
      end
      if (stage_ready[3]) begin
         rescale_mag_ff    <= rescale_mag_in;
         rescale_neg_ff[0] <= rescale_neg_in;
         pass_ff[3]        <= pass_ff[2];
         narrow_ff[3]      <= narrow_ff[2];
      end
      if (stage_ready[4]) begin
         gain_prod_ff      <= gain_prod_in;
         rescale_neg_ff[1] <= rescale_neg_ff[0];
         pass_ff[4]        <= pass_ff[3];
         narrow_ff[4]      <= narrow_ff[3];
      end
      if (stage_ready[5]) begin
         display_ff <= display_in;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = display_ff;

`ifndef SYNTHESIS
   // an accepted request always lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   // a stalled output never drops items held in the pipeline
   a_stall_no_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
         |=> ($countones(valid_ff) >= $past($countones(valid_ff))))
      else $error("pipeline lost an item while the response was stalled");

   // a full pipeline with a stalled output takes no new request
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("request taken while the pipeline was full and stalled");

   // a stalled last stage keeps its result
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && (rsp_tdata == $past(rsp_tdata))))
      else $error("stalled response changed");
`endif

endmodule

`default_nettype wire

// ===== dv/medical_pixel_window_level_top_test.sv =====
// self-checking bench for the pixel window/level block: stream driver, result monitor,
// register programming and an in-bench model of the display mapping
// depends on mpwl_pkg and medical_pixel_window_level_top
module medical_pixel_window_level_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mpwl_pkg::*;

   localparam int          FRAC            = FRAC_BITS_DEFAULT;
   localparam longint      GRAY_CLAMP      = 32767;
   localparam longint      RESCALE_LIMIT   = 64'h0000_0000_ffff_ffff;
   localparam int          RANDOM_PHASES   = 10;
   localparam int          REQS_PER_PHASE  = 200;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          FINAL_CYCLES    = 16;
   localparam int          HOLDOFF_AT      = 700;
   localparam int          HOLDOFF_CYCLES  = 150;
   localparam int          MAX_REPORTS     = 10;
   localparam int unsigned CYCLE_LIMIT     = 500000;

   typedef struct {
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      int unsigned gap_after;
   } pixel_req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] display_gray;
   } gray_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;   // [7:0] first_byte, [15:8] second_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;        // [7:0] display_gray
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow copy of the register set used for prediction
   cfg_type         shadow_cfg;
   pixel_req_type   pending_reqs[$];
   gray_result_type expected_gray[$];

   int unsigned  queued_total = 0;
   int unsigned  accepted_total = 0;
   int unsigned  rsp_total = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  settings_total = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_gap_left = 0;
   int unsigned  recv_stall_left = 0;
   int unsigned  holdoff_left = 0;
   logic         holdoff_done = 1'b0;
   logic         sender_quiet = 1'b0;
   logic         receiver_quiet = 1'b0;
   logic         next_req_valid;
   logic         next_rsp_ready;
   pixel_req_type   drive_req;
   gray_result_type got_gray;

   medical_pixel_window_level_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // expected display value for one sample under the shadow registers
   function automatic logic [7:0] predict_display_gray(input logic [7:0] first_byte,
                                                       input logic [7:0] second_byte);
      logic [15:0] word;
      longint      gray;
      longint      sum;
      longint      rescaled;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] off;
      logic [63:0] level;
      logic [7:0]  pix;
      if (shadow_cfg.valid_bits <= NARROW_BITS) begin
         // narrow samples pass one byte straight through
         pix = shadow_cfg.little_endian ? first_byte : second_byte;
      end else begin
         word = shadow_cfg.little_endian ? {second_byte, first_byte} : {first_byte, second_byte};
         if (shadow_cfg.signed_pixels) begin
            gray = longint'($signed(word));
         end else begin
            gray = longint'(word);
         end
         // only little-endian samples are clamped to the symmetric range
         if (shadow_cfg.little_endian) begin
            if (gray > GRAY_CLAMP) gray = GRAY_CLAMP;
            if (gray < -GRAY_CLAMP) gray = -GRAY_CLAMP;
         end
         // rescale, truncate toward zero, saturate
         sum = gray * longint'($signed(shadow_cfg.rescale_slope))
               + longint'($signed(shadow_cfg.rescale_intercept));
         if (sum < 0) begin
            rescaled = -((-sum) >> FRAC);
         end else begin
            rescaled = sum >> FRAC;
         end
         if (rescaled > RESCALE_LIMIT) rescaled = RESCALE_LIMIT;
         if (rescaled < -RESCALE_LIMIT) rescaled = -RESCALE_LIMIT;
         // window gain and offset, clamp to display range
         mag  = (rescaled < 0) ? -rescaled : rescaled;
         prod = mag * {32'b0, shadow_cfg.window_gain};
         off  = {40'b0, shadow_cfg.window_offset};
         if (rescaled < 0) begin
            level = (prod >= off) ? 64'd0 : ((off - prod) >> FRAC);
         end else begin
            level = (prod + off) >> FRAC;
         end
         pix = (level > 64'd255) ? GRAY_WHITE : level[7:0];
      end
      if (shadow_cfg.invert_output) pix = GRAY_WHITE - pix;
      return pix;
   endfunction

   function automatic cfg_type make_settings(input logic [31:0] slope,
                                             input logic [31:0] intercept,
                                             input logic [31:0] gain,
                                             input logic [23:0] offset,
                                             input logic        le,
                                             input logic        sgn,
                                             input logic [4:0]  vbits,
                                             input logic        inv);
      cfg_type cfg;
      cfg.rescale_slope     = slope;
      cfg.rescale_intercept = intercept;
      cfg.window_gain       = gain;
      cfg.window_offset     = offset;
      cfg.little_endian     = le;
      cfg.signed_pixels     = sgn;
      cfg.valid_bits        = vbits;
      cfg.invert_output     = inv;
      return cfg;
   endfunction

   // mostly plausible window settings, sometimes raw register noise
   function automatic cfg_type random_settings();
      logic [31:0] slope;
      logic [31:0] intercept;
      logic [31:0] gain;
      logic [23:0] offset;
      logic [4:0]  vbits;
      if ($urandom_range(0, 3) == 0) begin
         slope     = $urandom;
         intercept = $urandom;
         gain      = $urandom;
         offset    = 24'($urandom);
      end else begin
         slope     = $urandom_range(1, 32'h30000);
         if ($urandom_range(0, 1)) slope = -slope;
         intercept = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
         gain      = $urandom_range(32'h40, 32'h40000);
         offset    = 24'($urandom_range(0, 24'hff0000));
      end
      vbits = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 8))
                                           : 5'($urandom_range(9, 31));
      return make_settings(slope, intercept, gain, offset, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), vbits, 1'($urandom_range(0, 1)));
   endfunction

   function automatic logic [7:0] corner_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h7f;
         3: return 8'h80;
         4: return 8'hfe;
         default: return 8'hff;
      endcase
   endfunction

   // one register write over the csr channel, shadow updated on the handshake
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_RESCALE_SLOPE:     shadow_cfg.rescale_slope     = value;
         REG_RESCALE_INTERCEPT: shadow_cfg.rescale_intercept = value;
         REG_WINDOW_GAIN:       shadow_cfg.window_gain       = value;
         REG_WINDOW_OFFSET:     shadow_cfg.window_offset     = value[23:0];
         REG_LITTLE_ENDIAN:     shadow_cfg.little_endian     = value[0];
         REG_SIGNED_PIXELS:     shadow_cfg.signed_pixels     = value[0];
         REG_VALID_BITS:        shadow_cfg.valid_bits        = value[4:0];
         REG_INVERT_OUTPUT:     shadow_cfg.invert_output     = value[0];
         default: ;
      endcase
   endtask

   task automatic program_settings(input cfg_type cfg);
      write_register(REG_RESCALE_SLOPE, cfg.rescale_slope);
      write_register(REG_RESCALE_INTERCEPT, cfg.rescale_intercept);
      write_register(REG_WINDOW_GAIN, cfg.window_gain);
      write_register(REG_WINDOW_OFFSET, {8'b0, cfg.window_offset});
      write_register(REG_LITTLE_ENDIAN, {31'b0, cfg.little_endian});
      write_register(REG_SIGNED_PIXELS, {31'b0, cfg.signed_pixels});
      write_register(REG_VALID_BITS, {27'b0, cfg.valid_bits});
      write_register(REG_INVERT_OUTPUT, {31'b0, cfg.invert_output});
      csr_valid <= 1'b0;
      settings_total++;
   endtask

   task automatic pick_idle_modes();
      sender_quiet    = ($urandom_range(0, 3) == 0);
      receiver_quiet <= ($urandom_range(0, 3) == 0);
   endtask

   task automatic queue_request(input logic [7:0] first_byte, input logic [7:0] second_byte);
      pixel_req_type item;
      item.first_byte  = first_byte;
      item.second_byte = second_byte;
      item.gap_after   = sender_quiet ? 0 : $urandom_range(0, 7);
      pending_reqs.push_back(item);
      queued_total++;
   endtask

   task automatic queue_random_request();
      if ($urandom_range(0, 7) == 0) begin
         queue_request(corner_byte(), corner_byte());
      end else begin
         queue_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   // block goes idle once every queued request has produced its result
   task automatic wait_for_results(input int settle);
      while (rsp_total < queued_total) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      shadow_cfg = make_settings(RESCALE_SLOPE_RST, RESCALE_INTERCEPT_RST, WINDOW_GAIN_RST,
                                 WINDOW_OFFSET_RST, 1'b1, 1'b0, VALID_BITS_RST, 1'b0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset defaults (unsigned): zero, full scale, 32767 and clamping above 32767
      pick_idle_modes();
      queue_request(8'h00, 8'h00);
      queue_request(8'hff, 8'hff);
      queue_request(8'hff, 8'h7f);
      queue_request(8'h00, 8'h80);
      queue_request(8'h34, 8'h12);
      wait_for_results(SETTLE_CYCLES);

      // big-endian signed, unit slope and gain, out-of-range width, no clamping
      program_settings(make_settings(32'h0001_0000, 32'h0, 32'h0001_0000, 24'h0,
                                     1'b0, 1'b1, 5'd17, 1'b0));
      queue_request(8'h80, 8'h00);
      queue_request(8'h7f, 8'hff);
      queue_request(8'h00, 8'h05);
      queue_request(8'hff, 8'hff);
      wait_for_results(SETTLE_CYCLES);

      // largest positive slope, intercept, gain and offset, inverted
      program_settings(make_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 24'hff_ffff,
                                     1'b1, 1'b0, 5'd31, 1'b1));
      queue_request(8'hff, 8'hff);
      queue_request(8'h00, 8'h00);
      wait_for_results(SETTLE_CYCLES);

      // most negative slope and intercept, signed little-endian
      program_settings(make_settings(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 24'h80_0000,
                                     1'b1, 1'b1, 5'd16, 1'b0));
      queue_request(8'h00, 8'h80);
      queue_request(8'hff, 8'h7f);
      queue_request(8'h01, 8'h00);
      wait_for_results(SETTLE_CYCLES);

      // narrow passthrough, low byte
      program_settings(make_settings(32'd3932, 32'h0, 32'd256, 24'h80_0000,
                                     1'b1, 1'b0, 5'd8, 1'b0));
      queue_request(8'ha5, 8'h5a);
      queue_request(8'h00, 8'hff);
      wait_for_results(SETTLE_CYCLES);

      // narrow passthrough, high byte, signed and inverted, zero width
      program_settings(make_settings(32'd3932, 32'h0, 32'd256, 24'h80_0000,
                                     1'b0, 1'b1, 5'd0, 1'b1));
      queue_request(8'ha5, 8'h5a);
      queue_request(8'hff, 8'h00);
      wait_for_results(SETTLE_CYCLES);

      // negative rescaled values, below and above the offset
      program_settings(make_settings(32'hffff_0000, 32'h0, 32'h0000_8000, 24'h80_0000,
                                     1'b0, 1'b0, 5'd9, 1'b0));
      queue_request(8'h00, 8'h10);
      queue_request(8'h10, 8'h00);
      wait_for_results(SETTLE_CYCLES);

      // random settings, random samples with corner bytes mixed in
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_idle_modes();
         program_settings(random_settings());
         repeat (REQS_PER_PHASE) queue_random_request();
         wait_for_results(SETTLE_CYCLES);
      end

      wait_for_results(FINAL_CYCLES);
      if (expected_gray.size() != 0) begin
         $display("%0d results never arrived", expected_gray.size());
      end
      $display("ran %0d requests under %0d register settings (directed corners then random)",
               accepted_total, settings_total + 1);
      $display("compared %0d results, %0d mismatches", rsp_total, mismatch_count);
      if (mismatch_count == 0 && expected_gray.size() == 0) begin
         $display("PASS medical_pixel_window_level_top");
      end else begin
         $display("FAIL medical_pixel_window_level_top");
      end
      $finish;
   end

   // request driver: predicts on acceptance, then offers the next request after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap_left = 0;
      end else begin
         next_req_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_gray.push_back({req_tdata[7:0], req_tdata[15:8],
                                     predict_display_gray(req_tdata[7:0], req_tdata[15:8])});
            accepted_total++;
            next_req_valid = 1'b0;
         end
         if (!next_req_valid) begin
            if (send_gap_left > 0) begin
               send_gap_left--;
            end else if (pending_reqs.size() > 0) begin
               drive_req = pending_reqs.pop_front();
               req_tdata <= {drive_req.second_byte, drive_req.first_byte};
               next_req_valid = 1'b1;
               send_gap_left = drive_req.gap_after;
            end
         end
         req_tvalid <= next_req_valid;
      end
   end

   // long receiver hold-off once, so the pipeline fills and backs up the requests
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_done <= 1'b0;
      end else if (!holdoff_done && accepted_total >= HOLDOFF_AT) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // result monitor: compare against the oldest expectation, then draw a stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_total++;
            if (expected_gray.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result %0d with no request outstanding", $realtime, rsp_tdata);
               end
            end else begin
               got_gray = expected_gray.pop_front();
               if (rsp_tdata !== got_gray.display_gray) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: bytes %02h %02h display_gray expected %0d got %0d",
                              $realtime, got_gray.first_byte, got_gray.second_byte,
                              got_gray.display_gray, rsp_tdata);
                  end
               end
            end
            recv_stall_left = receiver_quiet ? 0 : $urandom_range(0, 7);
         end
         if (holdoff_left != 0) begin
            next_rsp_ready = 1'b0;
         end else if (recv_stall_left > 0) begin
            recv_stall_left--;
            next_rsp_ready = 1'b0;
         end else begin
            next_rsp_ready = 1'b1;
         end
         rsp_tready <= next_rsp_ready;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_gray.size());
         $display("FAIL medical_pixel_window_level_top");
         $finish;
      end
   end

endmodule
